>>> hdl/tss_pkg.sv
// Shared types, constants and helpers for the tridiagonal sweep solver.
`default_nettype none
package tss_pkg;

    localparam int Q_W       = 32;
    localparam int WIDE_W    = 33;
    localparam int IDX_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int EPS_W     = 31;
    localparam int STAT_W    = 2;

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_PIVOT  = 2'd1,
        STAT_EDGE   = 2'd2,
        STAT_LENGTH = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KAPPA_LEFT  = 3'd0,
        CFG_MU_LEFT     = 3'd1,
        CFG_KAPPA_RIGHT = 3'd2,
        CFG_MU_RIGHT    = 3'd3,
        CFG_EPSILON     = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MUL_NONE     = 3'd0,
        MUL_A_ALPHA  = 3'd1,
        MUL_A_BETA   = 3'd2,
        MUL_KR_ALPHA = 3'd3,
        MUL_KR_BETA  = 3'd4,
        MUL_ALPHA_Y  = 3'd5
    } t_mul_op;

    typedef enum logic {
        DEN_ROW  = 1'b0,
        DEN_EDGE = 1'b1
    } t_den_sel;

    typedef enum logic [1:0] {
        NUM_B   = 2'd0,
        NUM_PHI = 2'd1,
        NUM_MR  = 2'd2
    } t_num_sel;

    typedef struct packed {
        logic                    en;
        logic [CFG_IDX_W-1:0]    idx;
        logic [Q_W-1:0]          data;
    } t_cfg_wr;

    typedef struct packed {
        logic signed [Q_W-1:0] a;
        logic signed [Q_W-1:0] c;
        logic signed [Q_W-1:0] b;
        logic signed [Q_W-1:0] phi;
    } t_row;

    typedef struct packed {
        logic             load_row;
        logic             seed;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_alpha;
        logic             wr_beta;
        logic [IDX_W-1:0] wr_addr;
        t_mul_op          mul_op;
        logic             den_load;
        t_den_sel         den_sel;
        logic             div_start;
        t_num_sel         num_sel;
        logic             y_from_div;
        logic             y_step;
    } t_dp_cmd;

    typedef struct packed {
        logic den_small;
        logic div_done;
    } t_dp_stat;

    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   sol_index;
        logic               last_result;
        t_status            status;
        logic               zero_sol;
    } t_out_ctl;

    // Clamp a wide signed value to the Q range
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [63:0] x);
        if (x > 64'(Q_MAX))
            return Q_MAX;
        else if (x < 64'(Q_MIN))
            return Q_MIN;
        else
            return x[Q_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> hdl/tss_if.sv
// Handshake channel interfaces: row input, solution output, config write.
`default_nettype none
interface tss_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] coef_a;
    logic [31:0] coef_c;
    logic [31:0] coef_b;
    logic [31:0] rhs;
    logic        last_row;
    modport source (output valid, coef_a, coef_c, coef_b, rhs, last_row, input ready);
    modport sink   (input valid, coef_a, coef_c, coef_b, rhs, last_row, output ready);
endinterface

interface tss_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] solution;
    logic [5:0]  sol_index;
    logic        last_result;
    logic [1:0]  status;
    modport source (output valid, solution, sol_index, last_result, status, input ready);
    modport sink   (input valid, solution, sol_index, last_result, status, output ready);
endinterface

interface tss_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/tss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
        if (i_re)
            o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hdl/tss_div.sv
// Radix-4 restoring divider: rounded, saturated Q quotient of num/den.
`default_nettype none
module tss_div
    import tss_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire signed [WIDE_W-1:0]  i_num,
    input  wire signed [WIDE_W-1:0]  i_den,
    output logic                     o_done,
    output logic signed [Q_W-1:0]    o_quot
);
    localparam int NW0   = WIDE_W + FRAC_BITS + 1;
    localparam int NW    = NW0 + (NW0 % 2);
    localparam int STEPS = NW / 2;
    localparam int CNTW  = $clog2(STEPS + 1);

    logic [NW-1:0]     r_n, n_n;
    logic [WIDE_W-1:0] r_rem, n_rem;
    logic [WIDE_W-1:0] r_m;
    logic [CNTW-1:0]   r_cnt;
    logic              r_busy, r_done;
    logic              r_neg, r_num_neg, r_num_zero, r_den_zero;

    logic [WIDE_W-1:0] abs_num, abs_den;
    logic [WIDE_W:0]   t;

    assign abs_num = i_num[WIDE_W-1] ? WIDE_W'(-i_num) : WIDE_W'(i_num);
    assign abs_den = i_den[WIDE_W-1] ? WIDE_W'(-i_den) : WIDE_W'(i_den);

    // two quotient bits per cycle
    always_comb begin
        n_n   = r_n;
        n_rem = r_rem;
        t     = '0;
        for (int k = 0; k < 2; k++) begin
            t   = {n_rem, n_n[NW-1]};
            n_n = n_n << 1;
            if (t >= {1'b0, r_m}) begin
                n_rem  = WIDE_W'(t - {1'b0, r_m});
                n_n[0] = 1'b1;
            end else begin
                n_rem = t[WIDE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNTW'(STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // adding half the divisor gives round to nearest, ties away from zero
            r_n        <= (NW'(abs_num) << FRAC_BITS) + NW'(abs_den >> 1);
            r_rem      <= '0;
            r_m        <= abs_den;
            r_neg      <= i_num[WIDE_W-1] ^ i_den[WIDE_W-1];
            r_num_neg  <= i_num[WIDE_W-1];
            r_num_zero <= (i_num == '0);
            r_den_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_n   <= n_n;
            r_rem <= n_rem;
        end
    end

    always_comb begin
        if (r_num_zero)
            o_quot = '0;
        else if (r_den_zero)
            o_quot = r_num_neg ? Q_MIN : Q_MAX;
        else if (r_neg)
            o_quot = (r_n > NW'(64'h8000_0000)) ? Q_MIN : Q_W'(-r_n[Q_W-1:0]);
        else
            o_quot = (r_n > NW'(64'h7FFF_FFFF)) ? Q_MAX : r_n[Q_W-1:0];
    end

    assign o_done = r_done;
endmodule
`default_nettype wire

>>> hdl/tss_dp.sv
// Datapath: config registers, coefficient RAMs, multiplier, divider, y register.
`default_nettype none
module tss_dp
    import tss_pkg::*;
#(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  t_cfg_wr                 i_cfg,
    input  t_row                    i_row,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat,
    output logic signed [Q_W-1:0]   o_y
);
    localparam int AW = $clog2(MAX_ROWS);
    localparam logic signed [63:0]       RND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [WIDE_W-1:0] ONE_Q    = WIDE_W'(64'sd1 <<< FRAC_BITS);

    logic signed [Q_W-1:0]   r_kl, r_ml, r_kr, r_mr;
    logic [EPS_W-1:0]        r_eps;
    t_row                    r_row;
    logic signed [63:0]      r_prod;
    logic signed [WIDE_W-1:0] r_den;
    logic signed [Q_W-1:0]   r_y;

    logic signed [Q_W-1:0]   alpha_rd, beta_rd, quot;
    logic signed [Q_W-1:0]   op_x, op_z, mq;
    logic signed [63:0]      rnd;
    logic signed [WIDE_W-1:0] num, abs_den_in, y_sum;
    logic                    ram_we_a, ram_we_b;
    logic [AW-1:0]           ram_waddr;
    logic [Q_W-1:0]          wdata_a, wdata_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kl  <= '0;
            r_ml  <= '0;
            r_kr  <= '0;
            r_mr  <= '0;
            r_eps <= EPS_W'(1);
        end else if (i_cfg.en) begin
            case (i_cfg.idx)
                CFG_KAPPA_LEFT:  r_kl  <= i_cfg.data;
                CFG_MU_LEFT:     r_ml  <= i_cfg.data;
                CFG_KAPPA_RIGHT: r_kr  <= i_cfg.data;
                CFG_MU_RIGHT:    r_mr  <= i_cfg.data;
                CFG_EPSILON:     r_eps <= i_cfg.data[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    assign ram_we_a  = i_cmd.seed | i_cmd.wr_alpha;
    assign ram_we_b  = i_cmd.seed | i_cmd.wr_beta;
    assign ram_waddr = i_cmd.seed ? AW'(1) : i_cmd.wr_addr[AW-1:0];
    assign wdata_a   = i_cmd.seed ? r_kl : quot;
    assign wdata_b   = i_cmd.seed ? r_ml : quot;

    tss_ram #(.WIDTH(Q_W), .DEPTH(MAX_ROWS)) u_alpha (
        .i_clk   (i_clk),
        .i_we    (ram_we_a),
        .i_waddr (ram_waddr),
        .i_wdata (wdata_a),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr[AW-1:0]),
        .o_rdata (alpha_rd)
    );

    tss_ram #(.WIDTH(Q_W), .DEPTH(MAX_ROWS)) u_beta (
        .i_clk   (i_clk),
        .i_we    (ram_we_b),
        .i_waddr (ram_waddr),
        .i_wdata (wdata_b),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr[AW-1:0]),
        .o_rdata (beta_rd)
    );

    always_comb begin
        op_x = r_row.a;
        op_z = alpha_rd;
        case (i_cmd.mul_op)
            MUL_A_ALPHA:  begin op_x = r_row.a; op_z = alpha_rd; end
            MUL_A_BETA:   begin op_x = r_row.a; op_z = beta_rd;  end
            MUL_KR_ALPHA: begin op_x = r_kr;    op_z = alpha_rd; end
            MUL_KR_BETA:  begin op_x = r_kr;    op_z = beta_rd;  end
            MUL_ALPHA_Y:  begin op_x = alpha_rd; op_z = r_y;     end
            default: ;
        endcase
    end

    // rounded product: nearest, ties toward +inf, then clamped
    assign rnd = r_prod + RND_HALF;
    assign mq  = sat_q(rnd >>> FRAC_BITS);

    always_comb begin
        case (i_cmd.num_sel)
            NUM_PHI: num = WIDE_W'(r_row.phi) + WIDE_W'(mq);
            NUM_MR:  num = WIDE_W'(r_mr) + WIDE_W'(mq);
            default: num = WIDE_W'(r_row.b);
        endcase
    end

    assign abs_den_in = r_den[WIDE_W-1] ? WIDE_W'(-r_den) : r_den;
    assign o_stat.den_small = ({1'b0, abs_den_in} < (WIDE_W+1)'(r_eps));
    assign y_sum = WIDE_W'(mq) + WIDE_W'(beta_rd);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_row)
            r_row <= i_row;
        if (i_cmd.mul_op != MUL_NONE)
            r_prod <= op_x * op_z;
        if (i_cmd.den_load)
            r_den <= (i_cmd.den_sel == DEN_EDGE) ? ONE_Q - WIDE_W'(mq)
                                                 : WIDE_W'(r_row.c) - WIDE_W'(mq);
        if (i_cmd.y_from_div)
            r_y <= quot;
        else if (i_cmd.y_step)
            r_y <= sat_q(64'(y_sum));
    end

    tss_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (num),
        .i_den   (r_den),
        .o_done  (o_stat.div_done),
        .o_quot  (quot)
    );

    assign o_y = r_y;
endmodule
`default_nettype wire

>>> hdl/tss_ctrl.sv
// Controller: row counting, fault tracking and the sweep sequence.
`default_nettype none
module tss_ctrl
    import tss_pkg::*;
#(
    parameter int MAX_ROWS = 64
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    input  wire       i_last_row,
    output logic      o_in_ready,
    input  wire       i_out_ready,
    input  t_dp_stat  i_stat,
    output t_dp_cmd   o_cmd,
    output t_out_ctl  o_out
);
    localparam int CW = $clog2(MAX_ROWS + 1);

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_DECIDE = 16'h0002,
        S_RMUL   = 16'h0004,
        S_RDEN   = 16'h0008,
        S_RCHK   = 16'h0010,
        S_RDIVA  = 16'h0020,
        S_RDIVB  = 16'h0040,
        S_EMUL   = 16'h0080,
        S_EDEN   = 16'h0100,
        S_ECHK   = 16'h0200,
        S_EGO    = 16'h0400,
        S_EWAIT  = 16'h0800,
        S_OUT    = 16'h1000,
        S_SRD    = 16'h2000,
        S_SY     = 16'h4000,
        S_ERR    = 16'h8000
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    t_status          r_fault, n_fault;
    logic [IDX_W-1:0] r_frow, n_frow;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_last;
    logic             go_row;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_fault = r_fault;
        n_frow  = r_frow;
        n_idx   = r_idx;
        go_row  = 1'b0;
        o_cmd   = '0;
        o_cmd.mul_op  = MUL_NONE;
        o_cmd.den_sel = DEN_ROW;
        o_cmd.num_sel = NUM_B;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_row = 1'b1;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_fault == STAT_OK) begin
                    if (r_cnt == '0) begin
                        o_cmd.seed = 1'b1;
                        if (r_last) begin
                            n_fault = STAT_LENGTH;
                            n_frow  = '0;
                        end
                    end else if (!r_last) begin
                        if (r_cnt >= CW'(MAX_ROWS - 1)) begin
                            n_fault = STAT_LENGTH;
                            n_frow  = IDX_W'(MAX_ROWS - 1);
                        end else begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_addr = IDX_W'(r_cnt);
                            n_idx  = IDX_W'(r_cnt);
                            go_row = 1'b1;
                        end
                    end
                end
                if (!r_last) begin
                    if (r_cnt < CW'(MAX_ROWS))
                        n_cnt = r_cnt + 1'b1;
                    n_state = go_row ? S_RMUL : S_IDLE;
                end else if (r_fault != STAT_OK || r_cnt == '0) begin
                    n_state = S_ERR;
                end else begin
                    // edge row: n = rows seen so far
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = IDX_W'(r_cnt);
                    n_idx   = IDX_W'(r_cnt);
                    n_state = S_EMUL;
                end
            end
            S_RMUL: begin
                o_cmd.mul_op = MUL_A_ALPHA;
                n_state = S_RDEN;
            end
            S_RDEN: begin
                o_cmd.den_load = 1'b1;
                o_cmd.den_sel  = DEN_ROW;
                n_state = S_RCHK;
            end
            S_RCHK: begin
                if (i_stat.den_small) begin
                    n_fault = STAT_PIVOT;
                    n_frow  = r_idx;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.mul_op    = MUL_A_BETA;
                    o_cmd.div_start = 1'b1;
                    o_cmd.num_sel   = NUM_B;
                    n_state = S_RDIVA;
                end
            end
            S_RDIVA: begin
                if (i_stat.div_done) begin
                    o_cmd.wr_alpha  = 1'b1;
                    o_cmd.wr_addr   = r_idx + 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.num_sel   = NUM_PHI;
                    n_state = S_RDIVB;
                end
            end
            S_RDIVB: begin
                if (i_stat.div_done) begin
                    o_cmd.wr_beta = 1'b1;
                    o_cmd.wr_addr = r_idx + 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EMUL: begin
                o_cmd.mul_op = MUL_KR_ALPHA;
                n_state = S_EDEN;
            end
            S_EDEN: begin
                o_cmd.den_load = 1'b1;
                o_cmd.den_sel  = DEN_EDGE;
                n_state = S_ECHK;
            end
            S_ECHK: begin
                if (i_stat.den_small) begin
                    n_fault = STAT_EDGE;
                    n_frow  = r_idx;
                    n_state = S_ERR;
                end else begin
                    o_cmd.mul_op = MUL_KR_BETA;
                    n_state = S_EGO;
                end
            end
            S_EGO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.num_sel   = NUM_MR;
                n_state = S_EWAIT;
            end
            S_EWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.y_from_div = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_idx == '0) begin
                        n_cnt   = '0;
                        n_fault = STAT_OK;
                        n_frow  = '0;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_addr = r_idx;
                        n_state = S_SRD;
                    end
                end
            end
            S_SRD: begin
                o_cmd.mul_op = MUL_ALPHA_Y;
                n_state = S_SY;
            end
            S_SY: begin
                o_cmd.y_step = 1'b1;
                n_idx   = r_idx - 1'b1;
                n_state = S_OUT;
            end
            S_ERR: begin
                if (i_out_ready) begin
                    n_cnt   = '0;
                    n_fault = STAT_OK;
                    n_frow  = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_fault <= STAT_OK;
            r_frow  <= '0;
            r_idx   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_fault <= n_fault;
            r_frow  <= n_frow;
            r_idx   <= n_idx;
            if (r_state == S_IDLE && i_in_valid)
                r_last <= i_last_row;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_out.valid       = (r_state == S_OUT) || (r_state == S_ERR);
        o_out.zero_sol    = (r_state == S_ERR);
        o_out.sol_index   = (r_state == S_ERR) ? r_frow : r_idx;
        o_out.last_result = (r_state == S_ERR) || (r_idx == '0);
        o_out.status      = (r_state == S_ERR) ? r_fault : STAT_OK;
    end
endmodule
`default_nettype wire

>>> hdl/tridiagonal_sweep_solver.sv
// Top level: Thomas-method tridiagonal solver, controller plus datapath.
// Row 0 and rows after a fault need no arithmetic; a pivot fault ends at the pivot check, and a
//   middle row runs multiply, denominator, check and two radix-4 divisions (Q16.16 by default).
// Last row: y[n] follows the edge multiply, denominator, check and one division, and each further y
//   takes a read, multiply and update step plus any output stall; errors follow decide/edge check.
// One item at a time; sync active-low reset clears control state and config to defaults.
`default_nettype none
module tridiagonal_sweep_solver
    import tss_pkg::*;
#(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tss_in_if.sink      i_in,
    tss_out_if.source   o_out,
    tss_cfg_if.sink     i_cfg
);
    t_cfg_wr               cfg_wr;
    t_row                  row;
    t_dp_cmd               cmd;
    t_dp_stat              stat;
    t_out_ctl              out_ctl;
    logic signed [Q_W-1:0] y;

    // config writes are always taken
    assign i_cfg.ready = 1'b1;
    assign cfg_wr.en   = i_cfg.valid;
    assign cfg_wr.idx  = i_cfg.index;
    assign cfg_wr.data = i_cfg.data;

    assign row.a   = i_in.coef_a;
    assign row.c   = i_in.coef_c;
    assign row.b   = i_in.coef_b;
    assign row.phi = i_in.rhs;

    tss_ctrl #(.MAX_ROWS(MAX_ROWS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_last_row  (i_in.last_row),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_out       (out_ctl)
    );

    tss_dp #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_wr),
        .i_row   (row),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_y     (y)
    );

    // results come straight from registers; the error item carries zero
    assign o_out.valid       = out_ctl.valid;
    assign o_out.solution    = out_ctl.zero_sol ? '0 : y;
    assign o_out.sol_index   = out_ctl.sol_index;
    assign o_out.last_result = out_ctl.last_result;
    assign o_out.status      = out_ctl.status;
endmodule
`default_nettype wire
